/* rtl/scec_pkg.sv */
// Shared types and constants for the serial CRC encode/check unit.
// No dependencies.
package scec_pkg;

  localparam int CRC_WIDTH_DEF = 3;

  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_CHECK_MODE = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_GEN_LOW    = 1'b1;

  typedef struct packed {
    logic out_bit;
    logic is_check_bit;
    logic end_of_run;
    logic error_found;
    logic too_short;
  } result_t;

endpackage

/* rtl/serial_crc_encode_check_unit.sv */
// Top level of the bit-serial CRC encoder/checker.
// Depends on scec_pkg, scec_divider and scec_result_reg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one message bit per beat,
//   highest order first, with last_bit on the final bit. Output channel
//   (out_valid/out_ready) carries result beats.
//   Encode mode: every bit comes back as one beat; after the last bit the
//   CRC_WIDTH check bits follow, MSB first, the final one with end_of_run.
//   Check mode: one beat after the last bit with error_found.
//   Runs shorter than CRC_WIDTH+1 bits end with a single too_short beat.
//   Each input beat passes the input register, then the output register, to
//   its result beat. Throughput: one bit per cycle when not stalled. After the
//   last bit of a full encode run the input stalls for the zero-shift flush of
//   the divider, then while the check bits drain from the output register.
//   Reset clears remainder, length count, handshake state and sets the
//   registers to encode mode with generator low bits 1 (x^3+1 by default).
//   A stalled receiver holds the output beat; in encode mode one more input
//   beat may sit in the input register, then in_ready drops.
//   Configuration writes are taken at once on cfg_we.
module serial_crc_encode_check_unit import scec_pkg::*; #(
  parameter int CRC_WIDTH = CRC_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CRC_WIDTH-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 data_bit,
  input  logic                 last_bit,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_bit,
  output logic                 is_check_bit,
  output logic                 end_of_run,
  output logic                 error_found,
  output logic                 too_short
);

  logic                 check_mode;
  logic [CRC_WIDTH-1:0] gen_low;

  logic    ir_valid;
  logic    ir_data;
  logic    ir_last;
  logic    take;
  logic    load;
  logic    out_free;
  result_t result;
  result_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_mode <= 1'b0;
      gen_low    <= CRC_WIDTH'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHECK_MODE: check_mode <= cfg_data[0];
        REG_GEN_LOW:    gen_low    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_ready = !ir_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (in_ready) begin
      ir_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ir_data <= data_bit;
      ir_last <= last_bit;
    end
  end

  scec_divider #(
    .CRC_WIDTH(CRC_WIDTH)
  ) u_divider (
    .clk        (clk),
    .rst        (rst),
    .ir_valid   (ir_valid),
    .ir_data    (ir_data),
    .ir_last    (ir_last),
    .check_mode (check_mode),
    .gen_low    (gen_low),
    .out_free   (out_free),
    .take       (take),
    .load       (load),
    .result     (result)
  );

  scec_result_reg u_result (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .result    (result),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_free  (out_free),
    .held      (held)
  );

  assign out_bit      = held.out_bit;
  assign is_check_bit = held.is_check_bit;
  assign end_of_run   = held.end_of_run;
  assign error_found  = held.error_found;
  assign too_short    = held.too_short;

endmodule

/* rtl/scec_divider.sv */
// Division datapath: remainder and length state, per-bit step, end-of-message
// remainder flush and check-bit sequencing. Depends on scec_pkg.
module scec_divider import scec_pkg::*; #(
  parameter int CRC_WIDTH = CRC_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 ir_valid,
  input  logic                 ir_data,
  input  logic                 ir_last,
  input  logic                 check_mode,
  input  logic [CRC_WIDTH-1:0] gen_low,
  input  logic                 out_free,
  output logic                 take,
  output logic                 load,
  output result_t              result
);

  localparam int LEN_W = $clog2(CRC_WIDTH + 2);
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(CRC_WIDTH + 1);
  localparam int CNT_W = (CRC_WIDTH > 1) ? $clog2(CRC_WIDTH) : 1;
  localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(CRC_WIDTH - 1);

  typedef enum logic [1:0] {ST_RUN, ST_SHIFT, ST_EMIT} state_t;

  state_t               state;
  logic [CRC_WIDTH-1:0] remainder;
  logic [LEN_W-1:0]     length_count;
  logic [CNT_W-1:0]     cnt;

  logic [CRC_WIDTH-1:0] rem_step;
  logic [LEN_W-1:0]     len_step;
  logic                 short_run;
  logic                 need_out;

  function automatic logic [CRC_WIDTH-1:0] div_shift(input logic [CRC_WIDTH-1:0] r,
                                                     input logic                 b,
                                                     input logic [CRC_WIDTH-1:0] g);
    logic [CRC_WIDTH-1:0] s;
    s = (r << 1) | CRC_WIDTH'(b);
    if (r[CRC_WIDTH-1]) begin
      s = s ^ g;
    end
    return s;
  endfunction

  always_comb begin
    rem_step  = div_shift(remainder, ir_data, gen_low);
    len_step  = (length_count < LEN_FULL) ? length_count + LEN_W'(1) : length_count;
    short_run = len_step < LEN_FULL;
    need_out  = !check_mode || ir_last;
    take      = 1'b0;
    load      = 1'b0;
    result    = '0;
    case (state)
      ST_RUN: begin
        take = ir_valid && (!need_out || out_free);
        load = take && need_out;
        if (check_mode) begin
          result.end_of_run  = 1'b1;
          result.error_found = !short_run && (|rem_step);
          result.too_short   = short_run;
        end else begin
          result.out_bit    = ir_data;
          result.end_of_run = ir_last && short_run;
          result.too_short  = ir_last && short_run;
        end
      end
      ST_EMIT: begin
        load                = out_free;
        result.out_bit      = remainder[CRC_WIDTH-1];
        result.is_check_bit = 1'b1;
        result.end_of_run   = (cnt == '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_RUN;
      remainder    <= '0;
      length_count <= '0;
      cnt          <= '0;
    end else begin
      case (state)
        ST_RUN: begin
          if (take) begin
            if (ir_last) begin
              length_count <= '0;
              if (!check_mode && !short_run) begin
                remainder <= rem_step;
                cnt       <= CNT_TOP;
                state     <= ST_SHIFT;
              end else begin
                remainder <= '0;
              end
            end else begin
              remainder    <= rem_step;
              length_count <= len_step;
            end
          end
        end
        ST_SHIFT: begin
          remainder <= div_shift(remainder, 1'b0, gen_low);
          if (cnt == '0) begin
            cnt   <= CNT_TOP;
            state <= ST_EMIT;
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            remainder <= remainder << 1;
            if (cnt == '0) begin
              state <= ST_RUN;
            end else begin
              cnt <= cnt - CNT_W'(1);
            end
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

endmodule

/* rtl/scec_result_reg.sv */
// Output register for result beats with valid/ready handshake.
// Depends on scec_pkg.
module scec_result_reg import scec_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t result,
  input  logic    out_ready,
  output logic    out_valid,
  output logic    out_free,
  output result_t held
);

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

/* rtl/scec_checker.sv */
// Port-level checks for serial_crc_encode_check_unit, attached by bind.
// Depends on the top level's port names only.
module scec_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic out_bit,
  input logic is_check_bit,
  input logic end_of_run,
  input logic error_found,
  input logic too_short
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_bit) && $stable(is_check_bit)
      && $stable(end_of_run) && $stable(error_found) && $stable(too_short))
    else $error("output beat changed while stalled");

  a_check_bit_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_check_bit |-> !error_found && !too_short)
    else $error("check bit beat carries status flags");

  a_status_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && (error_found || too_short) |-> end_of_run && !is_check_bit)
    else $error("status flag outside final beat");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind serial_crc_encode_check_unit scec_checker u_scec_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_bit      (out_bit),
  .is_check_bit (is_check_bit),
  .end_of_run   (end_of_run),
  .error_found  (error_found),
  .too_short    (too_short)
);
